// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL file that carries checks (the block top).
// No dependencies; the user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, off while in reset.
`define GLVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain property, checked while in reset too.
`define GLVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/glvr_pkg.sv =====
// Shared types and constants for the goal-limited velocity ramp.
// No dependencies.
package glvr_pkg;

  localparam int FS_W    = 31;
  localparam int RAMP_W  = 16;
  localparam int DIST_W  = 32;
  localparam int FRAC_W  = 15;
  localparam int TICK_W  = 16;
  localparam int VEL_W   = 32;
  localparam int IDX_W   = 2;
  localparam int CNT_W   = 6;

  localparam int DIV_STEPS  = 46;  // quotient bits of (frac*peak)/(64*ramp)
  localparam int SQRT_STEPS = 32;  // root bits of a 64-bit radicand

  localparam logic [IDX_W-1:0] REG_FULL_SPEED = 2'd0;
  localparam logic [IDX_W-1:0] REG_RAMP_UP    = 2'd1;
  localparam logic [IDX_W-1:0] REG_RAMP_DOWN  = 2'd2;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_PEAK = 10'b0000000010,
    ST_PROD = 10'b0000000100,
    ST_LDA  = 10'b0000001000,
    ST_DIVA = 10'b0000010000,
    ST_LDD  = 10'b0000100000,
    ST_DIVD = 10'b0001000000,
    ST_MUL  = 10'b0010000000,
    ST_SQRT = 10'b0100000000,
    ST_FIN  = 10'b1000000000
  } glvr_state_t;

  typedef struct packed {
    logic load_in;
    logic peak;
    logic prod;
    logic div_load;
    logic div_step;
    logic div_dn;     // selects ramp-down time / dec result
    logic div_save;
    logic mul;
    logic sqrt_step;
    logic fin;
  } glvr_cmd_t;

  typedef struct packed {
    logic out_full;
  } glvr_sts_t;

endpackage

// ===== hw/rtl/glvr_ctrl.sv =====
// Sequencer for the velocity ramp: walks the datapath through its steps.
// Depends on glvr_pkg.
module glvr_ctrl import glvr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_stall,
  input  glvr_sts_t sts,
  output logic      in_stall,
  output glvr_cmd_t cmd
);

  glvr_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_free;

  assign out_free = !sts.out_full || !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_PEAK;
        end
      end
      ST_PEAK: begin
        cmd.peak  = 1'b1;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = ST_LDA;
      end
      ST_LDA: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIVA;
      end
      ST_DIVA: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_save = 1'b1;
          state_nxt    = ST_LDD;
        end
      end
      ST_LDD: begin
        cmd.div_load = 1'b1;
        cmd.div_dn   = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.div_step = 1'b1;
        cmd.div_dn   = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cmd.div_save = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/glvr_dp.sv =====
// Datapath: config registers, multipliers, shared restoring divider,
// digit-by-digit square root and the kept velocity. Depends on glvr_pkg.
module glvr_dp import glvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  glvr_cmd_t                cmd,
  output glvr_sts_t                sts,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [FS_W-1:0]          cfg_wdata,
  input  logic signed [DIST_W-1:0] in_remaining_distance,
  input  logic [FRAC_W-1:0]        in_speed_fraction,
  input  logic [TICK_W-1:0]        in_tick_period,
  input  logic                     out_stall,
  output logic                     out_valid,
  output logic signed [VEL_W-1:0]  out_velocity
);

  logic [FS_W-1:0]   fs_r;
  logic [RAMP_W-1:0] up_r, dn_r;

  logic signed [DIST_W-1:0] dist_r;
  logic [FRAC_W-1:0]        frac_r;
  logic [TICK_W-1:0]        tick_r;
  logic signed [VEL_W-1:0]  cur_r;

  logic [FS_W-1:0] peak_r, acc_r, dec_r, step_r;
  logic [45:0]     num_r, work_r;
  logic [21:0]     dvs_r, rem_r;
  logic [63:0]     x_r;
  logic [31:0]     root_r;
  logic [33:0]     srem_r;
  logic            wrong_r, out_valid_r;
  logic signed [VEL_W-1:0] vel_r;

  // peak
  logic [45:0] peak_prod;
  logic [31:0] peak_sh;
  assign peak_prod = {16'd0, frac_r} * {15'd0, fs_r};
  assign peak_sh   = peak_prod[45:14];

  // divider
  logic [RAMP_W-1:0] ramp_sel, ramp_eff;
  logic [22:0]       rem_sh, rem_sub;
  logic              dge;
  logic [45:0]       work_nxt;
  logic [FS_W-1:0]   quo_sat;
  assign ramp_sel = cmd.div_dn ? dn_r : up_r;
  assign ramp_eff = (ramp_sel == '0) ? RAMP_W'(1) : ramp_sel;
  assign rem_sh   = {rem_r, work_r[45]};
  assign dge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub  = rem_sh - {1'b0, dvs_r};
  assign work_nxt = {work_r[44:0], dge};
  assign quo_sat  = (|work_nxt[45:31]) ? {FS_W{1'b1}} : work_nxt[30:0];

  // sign / direction
  logic        neg, wrong;
  logic [31:0] mag;
  assign neg   = dist_r[DIST_W-1];
  assign mag   = neg ? (32'd0 - dist_r) : dist_r;
  assign wrong = (!neg && (dist_r != '0) && cur_r[VEL_W-1])
              || (neg && !cur_r[VEL_W-1] && (cur_r != '0));

  // step and radicand
  logic [46:0] step_prod;
  logic [62:0] rad_prod;
  assign step_prod = {16'd0, (wrong ? dec_r : acc_r)} * {31'd0, tick_r};
  assign rad_prod  = {32'd0, dec_r} * {31'd0, mag};

  // square root
  logic [33:0] s_sh, s_trial;
  logic        sge;
  assign s_sh    = {srem_r[31:0], x_r[63:62]};
  assign s_trial = {root_r, 2'b01};
  assign sge     = s_sh >= s_trial;

  // final update and clip
  logic signed [33:0] stp_s, sum;
  logic [FS_W-1:0]    cap;
  logic signed [33:0] cap_s;
  logic signed [VEL_W-1:0] v_new;
  assign stp_s = neg ? -$signed({3'd0, step_r}) : $signed({3'd0, step_r});
  assign sum   = $signed({{2{cur_r[VEL_W-1]}}, cur_r}) + stp_s;
  assign cap   = (!wrong_r && (root_r < {1'b0, peak_r})) ? root_r[30:0] : peak_r;
  assign cap_s = $signed({3'd0, cap});
  always_comb begin
    if (sum > cap_s)       v_new = VEL_W'(cap_s);
    else if (sum < -cap_s) v_new = VEL_W'(-cap_s);
    else                   v_new = VEL_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r        <= FS_W'(1179648);
      up_r        <= RAMP_W'(256);
      dn_r        <= RAMP_W'(256);
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FULL_SPEED: fs_r <= cfg_wdata;
          REG_RAMP_UP:    up_r <= cfg_wdata[RAMP_W-1:0];
          REG_RAMP_DOWN:  dn_r <= cfg_wdata[RAMP_W-1:0];
          default: ;
        endcase
      end
      if (cmd.fin) begin
        cur_r       <= v_new;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dist_r <= in_remaining_distance;
      frac_r <= in_speed_fraction;
      tick_r <= in_tick_period;
    end
    if (cmd.peak) peak_r <= peak_sh[31] ? {FS_W{1'b1}} : peak_sh[30:0];
    if (cmd.prod) num_r <= {15'd0, frac_r} * {15'd0, peak_r};
    if (cmd.div_load) begin
      work_r <= num_r;
      rem_r  <= '0;
      dvs_r  <= {ramp_eff, 6'd0};
    end else if (cmd.div_step) begin
      work_r <= work_nxt;
      rem_r  <= dge ? rem_sub[21:0] : rem_sh[21:0];
    end
    if (cmd.div_save) begin
      if (cmd.div_dn) dec_r <= quo_sat;
      else            acc_r <= quo_sat;
    end
    if (cmd.mul) begin
      step_r  <= step_prod[46:16];
      wrong_r <= wrong;
      x_r     <= {rad_prod, 1'b0};
      root_r  <= '0;
      srem_r  <= '0;
    end else if (cmd.sqrt_step) begin
      x_r    <= {x_r[61:0], 2'b00};
      srem_r <= sge ? (s_sh - s_trial) : s_sh;
      root_r <= {root_r[30:0], sge};
    end
    if (cmd.fin) vel_r <= v_new;
  end

  assign sts.out_full = out_valid_r;
  assign out_valid    = out_valid_r;
  assign out_velocity = vel_r;

endmodule

// ===== hw/rtl/goal_limited_velocity_ramp.sv =====
// Goal-limited velocity ramp: one item in, one velocity beat out, one item
// at a time. From acceptance to the result beat an item passes through a
// peak multiply, a product, two restoring divisions of 46 quotient bits
// (accel and decel, each with a load step) on one shared divider, a
// multiply, a square root of 32 root bits and a final clip. in_stall stays
// high from acceptance until the result is written to the output register;
// the next item is taken while that result may still be waiting. A beat
// stalled at the output holds the block in its last step. Configuration
// must be written through cfg_we/cfg_index/cfg_wdata only while idle; the
// block does not enforce this. Index 0 full speed, 1 ramp-up time, 2 ramp-down time.
// Depends on glvr_pkg, glvr_ctrl, glvr_dp and assert_macros.svh.
`include "assert_macros.svh"
module goal_limited_velocity_ramp import glvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [DIST_W-1:0] in_remaining_distance,
  input  logic [FRAC_W-1:0]        in_speed_fraction,
  input  logic [TICK_W-1:0]        in_tick_period,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VEL_W-1:0]  out_velocity,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [FS_W-1:0]          cfg_wdata
);

  glvr_cmd_t cmd;
  glvr_sts_t sts;

  // sequencer
  glvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // arithmetic and kept velocity
  glvr_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_remaining_distance (in_remaining_distance),
    .in_speed_fraction     (in_speed_fraction),
    .in_tick_period        (in_tick_period),
    .out_stall             (out_stall),
    .out_valid             (out_valid),
    .out_velocity          (out_velocity)
  );

  // an accepted item keeps the input closed on the next cycle
  `GLVR_ASSERT(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "not busy after accept")
  // a fresh result beat means the sequencer has just gone back to idle
  `GLVR_ASSERT(a_idle_after_result, $rose(out_valid) |-> !in_stall, "result without idle")
  // the output register only fills from the final step, never on accept
  `GLVR_ASSERT(a_no_result_on_accept, (in_valid && !in_stall && !out_valid) |=> !out_valid,
    "result appeared on accept")

endmodule

// ===== tb/goal_limited_velocity_ramp_checker.sv =====
// Checker for the goal-limited velocity ramp: watches the input, result and
// configuration ports, predicts each velocity beat and compares it in order.
// Depends on glvr_pkg only.
`timescale 1ns / 1ps
module goal_limited_velocity_ramp_checker import glvr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [DIST_W-1:0] in_remaining_distance,
  input  logic [FRAC_W-1:0]        in_speed_fraction,
  input  logic [TICK_W-1:0]        in_tick_period,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [VEL_W-1:0]  out_velocity,
  input  logic                     cfg_we,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [FS_W-1:0]          cfg_wdata,
  output int                       errors,
  output int                       pending,
  output int                       beats_checked
);

  localparam longint unsigned SAT31 = 64'h7FFF_FFFF;

  logic [FS_W-1:0]          speed_max;
  logic [RAMP_W-1:0]        ramp_up, ramp_dn;
  logic signed [VEL_W-1:0]  vel_now;
  logic signed [VEL_W-1:0]  vel_expected[$];

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned root, trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic longint unsigned ramp_rate(input longint unsigned frac,
                                                input longint unsigned peak,
                                                input longint unsigned ramp);
    longint unsigned r, a;
    r = (ramp == 0) ? 1 : ramp;  // zero ramp time acts as 1/256 s
    a = (frac * peak) / (64 * r);
    return (a > SAT31) ? SAT31 : a;
  endfunction

  function automatic logic signed [VEL_W-1:0] ramp_velocity(
      input logic signed [DIST_W-1:0] goal_dist, input logic [FRAC_W-1:0] frac,
      input logic [TICK_W-1:0] tick, input logic signed [VEL_W-1:0] vel);
    longint unsigned peak, acc, dec, step, mag, cap;
    longint v;
    logic toward_neg, wrong_way;
    toward_neg = goal_dist < 0;
    mag  = toward_neg ? longint'(-longint'(goal_dist)) : longint'(goal_dist);
    peak = (longint'(frac) * longint'(speed_max)) >> 14;
    if (peak > SAT31) peak = SAT31;
    acc = ramp_rate(frac, peak, ramp_up);
    dec = ramp_rate(frac, peak, ramp_dn);
    v = vel;
    wrong_way = (goal_dist > 0 && vel < 0) || (goal_dist < 0 && vel > 0);
    if (wrong_way) begin
      step = (dec * tick) >> 16;
    end else begin
      step = (acc * tick) >> 16;
      cap = floor_sqrt(2 * dec * mag);
      if (cap < peak) peak = cap;
    end
    v = toward_neg ? v - longint'(step) : v + longint'(step);
    if (v > longint'(peak)) v = peak;
    else if (v < -longint'(peak)) v = -longint'(peak);
    return v[VEL_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  initial begin
    errors = 0;
    beats_checked = 0;
  end

  assign pending = vel_expected.size();

  always @(posedge clk) begin
    logic signed [VEL_W-1:0] want;
    if (!rst_n) begin
      speed_max <= 31'd1179648;
      ramp_up   <= 16'd256;
      ramp_dn   <= 16'd256;
      vel_now   <= '0;
      vel_expected.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FULL_SPEED: speed_max <= cfg_wdata;
          REG_RAMP_UP:    ramp_up   <= cfg_wdata[RAMP_W-1:0];
          REG_RAMP_DOWN:  ramp_dn   <= cfg_wdata[RAMP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = ramp_velocity(in_remaining_distance, in_speed_fraction,
                             in_tick_period, vel_now);
        vel_now <= want;
        vel_expected.push_back(want);
      end
      if (out_valid && !out_stall) begin
        beats_checked++;
        if (vel_expected.size() == 0) begin
          report_mismatch($sformatf("velocity beat %0d with nothing expected",
                                    out_velocity));
        end else begin
          want = vel_expected.pop_front();
          if (out_velocity !== want)
            report_mismatch($sformatf("velocity got %0d want %0d",
                                      out_velocity, want));
        end
      end
    end
  end

endmodule

// ===== tb/goal_limited_velocity_ramp_test.sv =====
// Top of the velocity ramp testbench: clock, reset, stimulus, flow control
// and verdict. Depends on glvr_pkg, the block and the checker module.
`timescale 1ns / 1ps
module goal_limited_velocity_ramp_test;
  import glvr_pkg::*;

  // Longest quiet stretch a correct run can show: the HOLD_CYCLES receiver hold
  // on top of one item's processing, with lots of margin.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [DIST_W-1:0] in_remaining_distance = '0;
  logic [FRAC_W-1:0] in_speed_fraction = '0;
  logic [TICK_W-1:0] in_tick_period = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VEL_W-1:0] out_velocity;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = REG_FULL_SPEED;
  logic [FS_W-1:0] cfg_wdata = '0;

  int errors, pending, beats_checked;
  int gap_pct = 0;     // chance per cycle that the sender sits idle
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  logic hold_req = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int items_sent = 0;
  int cfg_writes = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  goal_limited_velocity_ramp DUT (.*);

  goal_limited_velocity_ramp_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_remaining_distance,
    .in_speed_fraction, .in_tick_period, .out_valid, .out_stall, .out_velocity,
    .cfg_we, .cfg_index, .cfg_wdata, .errors, .pending, .beats_checked
  );

  // Receiver: random stalls, plus one long hold-off counted here so the
  // block backs up and keeps in_stall high while the sender keeps offering.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input beat. Valid stays high into the next call unless a gap is
  // drawn there, so back-to-back items never drop it. in_stall is looked
  // at on the falling edge, where it is settled.
  task automatic offer_tick(input logic signed [DIST_W-1:0] goal_dist,
                            input logic [FRAC_W-1:0] frac,
                            input logic [TICK_W-1:0] tick);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_remaining_distance <= goal_dist;
    in_speed_fraction <= frac;
    in_tick_period <= tick;
    while (in_stall) @(negedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Wait out every expected beat plus the block's latency, so config
  // writes land while it is idle.
  task automatic drain;
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [FS_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  task automatic set_ramp(input logic [FS_W-1:0] fs, input logic [RAMP_W-1:0] up,
                          input logic [RAMP_W-1:0] dn);
    write_reg(REG_FULL_SPEED, fs);
    write_reg(REG_RAMP_UP, {15'd0, up});
    write_reg(REG_RAMP_DOWN, {15'd0, dn});
  endtask

  // Random run of control ticks. Mostly a plausible approach: the distance
  // keeps its sign and shrinks toward the goal, with random content; now
  // and then it jumps, flips sign, drops to zero or takes full-range values.
  task automatic random_ticks(input int count);
    logic signed [DIST_W-1:0] goal_dist;
    logic [FRAC_W-1:0] frac;
    logic [TICK_W-1:0] tick;
    logic signed [63:0] travel;
    int pick;
    goal_dist = $urandom >> $urandom_range(0, 20);
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) goal_dist = $urandom;
      else if (pick < 18) goal_dist = -goal_dist;
      else if (pick < 22) goal_dist = '0;
      else if (pick < 30) goal_dist = $signed($urandom) >>> $urandom_range(0, 31);
      else begin
        travel = (64'(signed'(out_velocity)) * $urandom_range(0, 6000)) >>> 16;
        travel = 64'(goal_dist) - travel;
        if (travel > 64'sh7FFF_FFFF || travel < -64'sh8000_0000) goal_dist = $urandom;
        else goal_dist = travel[31:0];
      end
      pick = $urandom_range(0, 9);
      frac = (pick < 2) ? 15'($urandom) : (pick < 3) ? 15'h7FFF :
             (pick < 4) ? 15'd0 : 15'($urandom_range(8192, 16384));
      pick = $urandom_range(0, 9);
      tick = (pick < 2) ? 16'($urandom) : (pick < 3) ? 16'd0 :
             16'($urandom_range(200, 8000));
      offer_tick(goal_dist, frac, tick);
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats at reset settings: field extremes, zero distance,
    // zero tick, full tick, and a reversal so the motion is away from goal.
    offer_tick(32'sh7FFF_FFFF, 15'h7FFF, 16'hFFFF);
    offer_tick(32'sh7FFF_FFFF, 15'h4000, 16'd6554);
    offer_tick(32'sh0010_0000, 15'h4000, 16'd0);
    offer_tick(-32'sh0010_0000, 15'h4000, 16'd6554);
    offer_tick(-32'sh0010_0000, 15'h4000, 16'hFFFF);
    offer_tick(32'sh8000_0000, 15'h7FFF, 16'hFFFF);
    offer_tick(32'sh0000_0001, 15'h4000, 16'd3277);
    offer_tick(32'sh0000_0000, 15'h4000, 16'hFFFF);
    offer_tick(32'sh0002_0000, 15'h0000, 16'hFFFF);
    offer_tick(32'sh0002_0000, 15'h0001, 16'h0001);
    offer_tick(-32'sh0000_0001, 15'h7FFF, 16'hFFFF);
    offer_tick(32'sh0005_0000, 15'h6000, 16'h8000);
    drain();

    // Extreme settings: fastest and slowest ramps (zero time acts as one), huge and zero speed.
    set_ramp(31'h7FFF_FFFF, 16'd0, 16'hFFFF);
    offer_tick(32'sh7FFF_FFFF, 15'h7FFF, 16'hFFFF);
    offer_tick(32'sh7FFF_FFFF, 15'h7FFF, 16'hFFFF);
    offer_tick(-32'sh8000_0000, 15'h7FFF, 16'hFFFF);
    offer_tick(32'sh0000_0100, 15'h7FFF, 16'hFFFF);
    drain();
    set_ramp(31'h7FFF_FFFF, 16'hFFFF, 16'd0);
    offer_tick(32'sh7FFF_FFFF, 15'h7FFF, 16'hFFFF);
    offer_tick(-32'sh0000_0100, 15'h7FFF, 16'hFFFF);
    offer_tick(32'sh7FFF_FFFF, 15'h7FFF, 16'hFFFF);
    drain();
    set_ramp(31'd0, 16'd1, 16'd1);
    offer_tick(32'sh7FFF_FFFF, 15'h7FFF, 16'hFFFF);
    offer_tick(-32'sh8000_0000, 15'h4000, 16'h8000);
    drain();

    // Random phases, each with its own settings and flow-control mix.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 83; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 83; end
        default: begin gap_pct = 30; stall_pct = 30; end
      endcase
      case (ph)
        0: set_ramp(31'd1179648, 16'd256, 16'd256);
        1: set_ramp(31'h7FFF_FFFF, 16'd1, 16'd1);
        2: set_ramp(31'($urandom), 16'($urandom), 16'($urandom));
        3: set_ramp(31'($urandom_range(0, 1 << 22)), 16'($urandom_range(1, 2048)),
                    16'($urandom_range(1, 2048)));
        default: set_ramp(31'($urandom_range(1 << 16, 1 << 21)),
                          16'($urandom_range(64, 1024)), 16'($urandom_range(0, 1024)));
      endcase
      if (ph == 0) begin
        // Long receiver hold while the sender keeps offering.
        hold_req = 1'b1;
      end
      random_ticks(78);
      // Sender pauses until every expected beat has come back.
      drain();
    end

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d control ticks, %0d velocity beats checked, %0d config writes,",
             items_sent, beats_checked, cfg_writes);
    $display("  across reset, extreme and random ramp settings with idle/stall mixes.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/glvr_pkg.sv
hw/rtl/glvr_ctrl.sv
hw/rtl/glvr_dp.sv
hw/rtl/goal_limited_velocity_ramp.sv
tb/goal_limited_velocity_ramp_checker.sv
tb/goal_limited_velocity_ramp_test.sv
